// ===== rtl/utv_pkg.sv =====
package utv_pkg;

	localparam int MAX_TEXT_BYTES = 4096;
	localparam int LEN_W = 13;
	localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 2);
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_MAX_LENGTH = 1'b0;
	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(4096);

	localparam logic [7:0] BYTE_TAB     = 8'h09;
	localparam logic [7:0] BYTE_LF      = 8'h0a;
	localparam logic [7:0] BYTE_CR      = 8'h0d;
	localparam logic [7:0] BYTE_SPACE   = 8'h20;
	localparam logic [7:0] ASCII_MAX    = 8'h7f;
	localparam logic [7:0] CONT_LO      = 8'h80;
	localparam logic [7:0] CONT_HI      = 8'hbf;
	localparam logic [7:0] E0_CONT_LO   = 8'ha0;
	localparam logic [7:0] ED_CONT_HI   = 8'h9f;
	localparam logic [7:0] F0_CONT_LO   = 8'h90;
	localparam logic [7:0] F4_CONT_HI   = 8'h8f;
	localparam logic [7:0] LEAD2_LO     = 8'hc2;
	localparam logic [7:0] LEAD2_HI     = 8'hdf;
	localparam logic [7:0] LEAD3_LO     = 8'he0;
	localparam logic [7:0] LEAD3_HI     = 8'hef;
	localparam logic [7:0] LEAD_ED      = 8'hed;
	localparam logic [7:0] LEAD4_LO     = 8'hf0;
	localparam logic [7:0] LEAD4_HI     = 8'hf4;

	typedef enum logic [2:0] {
		RULE_NORMAL,
		RULE_E0,
		RULE_ED,
		RULE_F0,
		RULE_F4
	} rule_t;

	typedef struct packed {
		logic             text_valid;
		logic [LEN_W-1:0] text_length;
	} result_t;

endpackage

// ===== rtl/utv_if.sv =====
interface utv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utv_result_if import utv_pkg::*;;
	logic             valid;
	logic             ready;
	logic             text_valid;
	logic [LEN_W-1:0] text_length;

	modport source (output valid, output text_valid, output text_length, input ready);
	modport sink (input valid, input text_valid, input text_length, output ready);
endinterface

// ===== rtl/utf8_text_validator.sv =====
// Channel   Role   Payload                              Transfer when
// text      sink   data_byte[7:0], last_byte            text.valid && text.ready
// result    source text_valid, text_length[12:0]        result.valid && result.ready
// apb       slave  max_length at byte addresses 0-3      psel && penable && pwrite && pready
//
// One byte per cycle sustained while no final byte is stalled; a byte is held in
// the input register while it is parsed, and a final byte's result is registered.
// Result valid rises with the registered result and holds until it transfers.
// The result register frees the parser while a result waits; only a final byte
// stalls, and only while the result register is full and not being taken.
// arst_n clears the message state, both valid flags and sets max_length to 4096.
module utf8_text_validator
	import utv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	utv_byte_if.sink              text,
	utv_result_if.source          result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [LEN_W-1:0] max_length;
	result_t          res_data;

	utv_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.max_length (max_length)
	);

	utv_validator_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (text.valid),
		.in_ready   (text.ready),
		.in_byte    (text.data_byte),
		.in_last    (text.last_byte),
		.max_length (max_length),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.res_data   (res_data)
	);

	assign result.text_valid  = res_data.text_valid;
	assign result.text_length = res_data.text_length;

endmodule

// ===== rtl/utv_apb_regs.sv =====
module utv_apb_regs
	import utv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [LEN_W-1:0]      max_length
);

	logic [LEN_W-1:0] max_length_q;
	logic             wr_en;
	logic             sel_max;

	assign pready  = 1'b1;
	assign sel_max = (paddr[APB_ADDR_W-1] == REG_MAX_LENGTH);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
		end else if (wr_en && sel_max) begin
			max_length_q <= pwdata[LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_max) begin
			prdata = APB_DATA_W'(max_length_q);
		end
	end

	assign max_length = max_length_q;

	a_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && sel_max |=> max_length_q == $past(pwdata[LEN_W-1:0]))
		else $error("max_length write lost");
	a_hold_without_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && sel_max) |=> $stable(max_length_q))
		else $error("max_length changed without write");
	a_read_back: assert property (@(posedge clk) disable iff (!arst_n)
		sel_max |-> prdata[LEN_W-1:0] == max_length_q)
		else $error("max_length read mismatch");

endmodule

// ===== rtl/utv_parser.sv =====
module utv_parser
	import utv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	input  logic [LEN_W-1:0] max_length,
	output result_t          result
);

	logic [1:0]       pend_q, pend_n;
	rule_t            rule_q, rule_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             err_q, err_n;
	logic             cont_ok;
	logic [CMP_W-1:0] limit;
	logic [CMP_W-1:0] cnt_ext;
	logic             ok;

	always_comb begin
		case (rule_q)
			RULE_E0: cont_ok = (data_byte >= E0_CONT_LO) && (data_byte <= CONT_HI);
			RULE_ED: cont_ok = (data_byte >= CONT_LO) && (data_byte <= ED_CONT_HI);
			RULE_F0: cont_ok = (data_byte >= F0_CONT_LO) && (data_byte <= CONT_HI);
			RULE_F4: cont_ok = (data_byte >= CONT_LO) && (data_byte <= F4_CONT_HI);
			default: cont_ok = (data_byte >= CONT_LO) && (data_byte <= CONT_HI);
		endcase
	end

	always_comb begin
		pend_n = pend_q;
		rule_n = rule_q;
		err_n  = err_q;
		cnt_n  = (cnt_q <= CNT_W'(MAX_TEXT_BYTES)) ? cnt_q + 1'b1 : cnt_q;
		if (!err_q) begin
			if (pend_q != 2'd0) begin
				if (!cont_ok) begin
					err_n = 1'b1;
				end else begin
					rule_n = RULE_NORMAL;
					pend_n = pend_q - 2'd1;
				end
			end else begin
				rule_n = RULE_NORMAL;
				if (data_byte <= ASCII_MAX) begin
					if (data_byte < BYTE_SPACE && data_byte != BYTE_TAB &&
					    data_byte != BYTE_LF && data_byte != BYTE_CR) begin
						err_n = 1'b1;
					end
				end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
					pend_n = 2'd1;
				end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
					pend_n = 2'd2;
					if (data_byte == LEAD3_LO) begin
						rule_n = RULE_E0;
					end else if (data_byte == LEAD_ED) begin
						rule_n = RULE_ED;
					end
				end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
					pend_n = 2'd3;
					if (data_byte == LEAD4_LO) begin
						rule_n = RULE_F0;
					end else if (data_byte == LEAD4_HI) begin
						rule_n = RULE_F4;
					end
				end else begin
					err_n = 1'b1;
				end
			end
		end
	end

	assign cnt_ext = CMP_W'(cnt_n);
	assign limit   = (CMP_W'(max_length) < CMP_W'(MAX_TEXT_BYTES)) ?
	                 CMP_W'(max_length) : CMP_W'(MAX_TEXT_BYTES);
	assign ok      = !err_n && (pend_n == 2'd0) && (cnt_ext <= limit);

	assign result.text_valid  = ok;
	assign result.text_length = ok ? cnt_ext[LEN_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			rule_q <= RULE_NORMAL;
			cnt_q  <= '0;
			err_q  <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				pend_q <= 2'd0;
				rule_q <= RULE_NORMAL;
				cnt_q  <= '0;
				err_q  <= 1'b0;
			end else begin
				pend_q <= pend_n;
				rule_q <= rule_n;
				cnt_q  <= cnt_n;
				err_q  <= err_n;
			end
		end
	end

	a_cnt_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_TEXT_BYTES + 1))
		else $error("byte count beyond saturation");
	a_rule_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd0 |-> rule_q == RULE_NORMAL)
		else $error("special rule with no continuation pending");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> cnt_q == '0 && !err_q && pend_q == 2'd0)
		else $error("state not cleared after final byte");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !(step && last_byte) |=> err_q)
		else $error("error flag dropped inside message");

endmodule

// ===== rtl/utv_validator_core.sv =====
module utv_validator_core
	import utv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic [LEN_W-1:0] max_length,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res_data
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       res_valid_q;
	result_t    res_q;
	result_t    parse_res;
	logic       out_free;
	logic       step;

	assign out_free = !res_valid_q || res_ready;
	assign step     = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || step;

	utv_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (byte_s1),
		.last_byte  (last_s1),
		.max_length (max_length),
		.result     (parse_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= step && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= parse_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_len_zero_when_bad: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.text_valid |-> res_q.text_length == '0)
		else $error("nonzero length on invalid text");
	a_len_nonzero_when_good: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.text_valid |-> res_q.text_length != '0)
		else $error("zero length on valid text");
	a_final_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && !out_free |=> valid_s1 && last_s1 && $stable(byte_s1))
		else $error("final byte advanced into full result register");
	a_result_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_free && !(step && last_s1) |=> !res_valid_q)
		else $error("result without final byte");

endmodule
